// ===== rtl/fdci_pkg.sv =====
// Shared types, register codes and constants of the feedback delay with cubic interpolation.
package fdci_pkg;

	// Parameter defaults
	localparam int DELAY_DEPTH_DEF  = 131072;
	localparam int NUM_CHANNELS_DEF = 2;
	localparam int SAMPLE_BITS_DEF  = 24;

	// Register field widths
	localparam int GAIN_W     = 16;
	localparam int DLEN_W     = 33;
	localparam int FB_W       = 17;
	localparam int FRAC_W     = 16;
	localparam int WHOLE_W    = DLEN_W - FRAC_W + 1;
	localparam int CFG_ADDR_W = 2;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_INPUT_GAIN    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_DELAY_LENGTH  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_GAIN = 2'd2;

	// Register reset values
	localparam logic [GAIN_W-1:0] INPUT_GAIN_RST    = 16'd3650;
	localparam logic [DLEN_W-1:0] DELAY_LENGTH_RST  = 33'd1887436800;
	localparam logic [FB_W-1:0]   FEEDBACK_GAIN_RST = 17'd16384;
	localparam logic [FB_W-1:0]   FB_UNITY          = 17'd65536;

	// Input gain is Q4.12, rounded half up before the shift
	localparam int GAIN_FRAC  = 12;
	localparam int ROUND_HALF = 2048;

	// Second operand of the shared multiplier (gain, fraction or feedback)
	localparam int MUL_B_W = 18;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_OUT
	} state_t;

	// Settings derived from the registers, handed to the datapath
	typedef struct packed {
		logic              busy;
		logic              zero;
		logic [FRAC_W:0]   t;
		logic [FB_W-1:0]   fb;
		logic [GAIN_W-1:0] gain;
	} cfg_t;

endpackage

// ===== rtl/fdci_cfg.sv =====
// Configuration registers and the settings derived from them (read offset, fraction, feedback).
module fdci_cfg #(
	parameter int DELAY_DEPTH = fdci_pkg::DELAY_DEPTH_DEF,
	localparam int IW = $clog2(DELAY_DEPTH)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fdci_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [fdci_pkg::DLEN_W-1:0]      cfg_wdata,
	output fdci_pkg::cfg_t                   cfg,
	output logic [IW-1:0]                    back
);

	localparam int WHOLE_W = fdci_pkg::WHOLE_W;
	localparam int FRAC_W  = fdci_pkg::FRAC_W;
	// Reciprocal of the depth, exact floor division for any whole-sample count
	localparam int SHIFT   = WHOLE_W + IW;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + longint'(DELAY_DEPTH) - 64'd1) / longint'(DELAY_DEPTH);
	localparam int RECIP_W = WHOLE_W + 2;
	localparam int RPW     = WHOLE_W + RECIP_W;

	logic [fdci_pkg::GAIN_W-1:0] gain_q;
	logic [fdci_pkg::DLEN_W-1:0] dlen_q;
	logic [fdci_pkg::FB_W-1:0]   fbg_q;
	logic [1:0]                  pend_q;

	logic [FRAC_W-1:0]  frac;
	logic [WHOLE_W-1:0] whole;
	logic [WHOLE_W-1:0] whole_s1;
	logic [RPW-1:0]     rprod_s1;
	logic [FRAC_W:0]    t_s1;
	logic               zero_s1;
	logic [fdci_pkg::FB_W-1:0] fb_s1;
	logic [WHOLE_W-1:0] quot;
	logic [WHOLE_W-1:0] rem;
	logic [IW-1:0]      back_s2;

	// Hold the registers; a write restarts the settling count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= fdci_pkg::INPUT_GAIN_RST;
			dlen_q <= fdci_pkg::DELAY_LENGTH_RST;
			fbg_q  <= fdci_pkg::FEEDBACK_GAIN_RST;
			pend_q <= 2'd2;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					fdci_pkg::REG_INPUT_GAIN:    gain_q <= cfg_wdata[fdci_pkg::GAIN_W-1:0];
					fdci_pkg::REG_DELAY_LENGTH:  dlen_q <= cfg_wdata;
					fdci_pkg::REG_FEEDBACK_GAIN: fbg_q  <= cfg_wdata[fdci_pkg::FB_W-1:0];
					default: ;
				endcase
				pend_q <= 2'd2;
			end else if (pend_q != 2'd0) begin
				pend_q <= pend_q - 2'd1;
			end
		end
	end

	// A fractional delay reads one sample further back
	assign frac  = dlen_q[FRAC_W-1:0];
	assign whole = WHOLE_W'(dlen_q[fdci_pkg::DLEN_W-1:FRAC_W]) + WHOLE_W'(frac != '0);

	// First stage: reciprocal product, fraction and clamped feedback
	always_ff @(posedge clk) begin
		whole_s1 <= whole;
		rprod_s1 <= RPW'(whole) * RPW'(RECIP_W'(RECIP));
		t_s1     <= (frac == '0) ? '0 : (FRAC_W + 1)'(fdci_pkg::FB_UNITY) - {1'b0, frac};
		zero_s1  <= (dlen_q == '0);
		fb_s1    <= (fbg_q > fdci_pkg::FB_UNITY) ? fdci_pkg::FB_UNITY : fbg_q;
	end

	// Second stage: remainder of the whole count by the depth
	assign quot = WHOLE_W'(rprod_s1 >> SHIFT);
	assign rem  = whole_s1 - WHOLE_W'(quot * WHOLE_W'(DELAY_DEPTH));

	always_ff @(posedge clk) begin
		back_s2 <= IW'(rem);
	end

	assign cfg.busy = (pend_q != 2'd0);
	assign cfg.zero = zero_s1;
	assign cfg.t    = t_s1;
	assign cfg.fb   = fb_s1;
	assign cfg.gain = gain_q;
	assign back     = back_s2;

endmodule

// ===== rtl/feedback_delay_cubic_interp.sv =====
// A beat reads four taps and is interpolated, then ST_OUT writes and returns the result;
// with zero delay ST_RD1 goes straight to ST_OUT. One sample is in flight at a time: four
// reads on the single delay-memory read port, four dependent steps of the shared
// multiplier, the write (held while the output is full) and the idle state taking the next
// beat. s_tready is held low after each register write while the read offset is derived.
// Reset clears the sequencer, write pointers and fill marks; an unwritten delay-memory entry
// reads as zero through the per-channel fill mark, so no clearing pass is needed.
module feedback_delay_cubic_interp #(
	parameter int DELAY_DEPTH  = fdci_pkg::DELAY_DEPTH_DEF,
	parameter int NUM_CHANNELS = fdci_pkg::NUM_CHANNELS_DEF,
	parameter int SAMPLE_BITS  = fdci_pkg::SAMPLE_BITS_DEF,
	localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fdci_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fdci_pkg::DLEN_W-1:0]     cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [TDW-1:0]                  s_tdata,  // sample_in
	input  logic [0:0]                      s_tuser,  // channel_sel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [TDW-1:0]                  m_tdata,  // sample_out
	output logic [0:0]                      m_tuser   // clipped
);

	localparam int IW     = $clog2(DELAY_DEPTH);
	localparam int CHW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SB     = SAMPLE_BITS;
	localparam int MA     = SB + 6;
	localparam int PW     = MA + fdci_pkg::MUL_B_W;
	localparam int SCW    = SB + 5;
	localparam int SUMW   = SB + 7;
	localparam int FRAC_W = fdci_pkg::FRAC_W;
	localparam longint SMAX = (longint'(1) << (SB - 1)) - 1;
	localparam logic signed [SUMW-1:0] SMAX_W = SUMW'(SMAX);
	localparam logic signed [SUMW-1:0] SMIN_W = -SMAX_W - SUMW'(1);
	localparam logic [IW:0]   DX1 = (IW + 1)'(DELAY_DEPTH);

	fdci_pkg::cfg_t   cfg;
	logic [IW-1:0]    back;
	fdci_pkg::state_t state_q, state_d;

	// Delay memory and per-channel write position
	logic [SB-1:0] dly_mem [NUM_CHANNELS][DELAY_DEPTH];
	logic [IW-1:0] wp_q   [NUM_CHANNELS];
	logic          wrap_q [NUM_CHANNELS];

	// Item registers
	logic [CHW-1:0]        ch_q;
	logic [IW-1:0]         wp_cur_q;
	logic [IW-1:0]         base_q;
	logic signed [SB-1:0]  smp_q;
	logic [CHW-1:0]        ch_in;
	logic [IW-1:0]         wp_in;
	logic [IW:0]           base_x;

	// Read port
	logic [IW:0]           idx_x;
	logic [IW-1:0]         rd_idx;
	logic [SB-1:0]         rd_data_s1;
	logic                  rd_vld_s1;
	logic signed [SB-1:0]  ysmp;

	// Interpolation datapath
	logic signed [SB-1:0]  y0_q, y1_q, y2_q;
	logic signed [MA-1:0]  y0x, y1x, y2x, y3x;
	logic signed [MA-1:0]  c1, c2, c3;
	logic signed [MA-1:0]  c1_q, c2_q;
	logic signed [MA-1:0]  dly_q;
	logic signed [SCW-1:0] scaled_q;
	logic signed [MA-1:0]  mul_a;
	logic signed [fdci_pkg::MUL_B_W-1:0] mul_b;
	logic                  mul_en;
	logic signed [PW-1:0]  prod_q;
	logic signed [MA-1:0]  prod_hi;
	logic signed [MA-1:0]  delayed;

	// Result
	logic signed [SUMW-1:0] sum_st, sum_out;
	logic signed [SUMW-1:0] sat_st, sat_out;
	logic                   clip_st, clip_out;
	logic                   out_free;
	logic                   mem_we;
	logic                   accept;
	logic                   m_valid_q;
	logic [SB-1:0]          m_data_q;
	logic                   m_clip_q;

	fdci_cfg #(
		.DELAY_DEPTH (DELAY_DEPTH)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg),
		.back      (back)
	);

	// Base read position of the arriving beat
	assign ch_in  = (NUM_CHANNELS > 1) ? CHW'(s_tuser[0]) : CHW'(0);
	assign wp_in  = wp_q[ch_in];
	assign base_x = {1'b0, wp_in} + ((wp_in >= back) ? '0 : DX1) - {1'b0, back};
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdci_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, handshake and shared multiplier operands
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mul_en   = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			fdci_pkg::ST_IDLE: begin
				s_tready = !cfg.busy;
				if (s_tvalid && !cfg.busy) begin
					state_d = fdci_pkg::ST_RD0;
				end
			end
			fdci_pkg::ST_RD0: begin
				mul_en  = 1'b1;
				mul_a   = MA'(smp_q);
				mul_b   = {2'b00, cfg.gain};
				state_d = fdci_pkg::ST_RD1;
			end
			fdci_pkg::ST_RD1: begin
				state_d = cfg.zero ? fdci_pkg::ST_OUT : fdci_pkg::ST_RD2;
			end
			fdci_pkg::ST_RD2: begin
				state_d = fdci_pkg::ST_RD3;
			end
			fdci_pkg::ST_RD3: begin
				state_d = fdci_pkg::ST_M1;
			end
			fdci_pkg::ST_M1: begin
				mul_en  = 1'b1;
				mul_a   = c3;
				mul_b   = {1'b0, cfg.t};
				state_d = fdci_pkg::ST_M2;
			end
			fdci_pkg::ST_M2: begin
				mul_en  = 1'b1;
				mul_a   = c2_q + prod_hi;
				mul_b   = {1'b0, cfg.t};
				state_d = fdci_pkg::ST_M3;
			end
			fdci_pkg::ST_M3: begin
				mul_en  = 1'b1;
				mul_a   = c1_q + prod_hi;
				mul_b   = {1'b0, cfg.t};
				state_d = fdci_pkg::ST_M4;
			end
			fdci_pkg::ST_M4: begin
				mul_en  = 1'b1;
				mul_a   = delayed;
				mul_b   = {1'b0, cfg.fb};
				state_d = fdci_pkg::ST_OUT;
			end
			fdci_pkg::ST_OUT: begin
				if (out_free) begin
					mem_we  = 1'b1;
					state_d = fdci_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fdci_pkg::ST_IDLE;
			end
		endcase
	end

	// Read index of the four taps around the base, wrapped by the depth
	always_comb begin
		case (state_q)
			fdci_pkg::ST_RD0: idx_x = {1'b0, base_q} + DX1 - (IW + 1)'(1);
			fdci_pkg::ST_RD2: idx_x = {1'b0, base_q} + (IW + 1)'(1);
			fdci_pkg::ST_RD3: idx_x = {1'b0, base_q} + (IW + 1)'(2);
			default:          idx_x = {1'b0, base_q};
		endcase
		rd_idx = IW'((idx_x >= DX1) ? idx_x - DX1 : idx_x);
	end

	// Memory: write the stored sample, read one tap per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dly_mem[ch_q][wp_cur_q] <= SB'(sat_st);
		end
		rd_data_s1 <= dly_mem[ch_q][rd_idx];
		rd_vld_s1  <= wrap_q[ch_q] || (rd_idx < wp_cur_q);
	end

	// Entries past the fill mark read as zero
	assign ysmp = rd_vld_s1 ? signed'(rd_data_s1) : '0;

	// Advance the write pointer and fill mark of the channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				wp_q[i]   <= '0;
				wrap_q[i] <= 1'b0;
			end
		end else if (mem_we) begin
			if (wp_cur_q == IW'(DELAY_DEPTH - 1)) begin
				wp_q[ch_q]   <= '0;
				wrap_q[ch_q] <= 1'b1;
			end else begin
				wp_q[ch_q] <= wp_cur_q + IW'(1);
			end
		end
	end

	// Interpolation coefficients, doubled units
	assign y0x = MA'(y0_q);
	assign y1x = MA'(y1_q);
	assign y2x = MA'(y2_q);
	assign y3x = MA'(ysmp);
	assign c1  = y2x - y0x;
	assign c2  = (y0x <<< 1) + (y2x <<< 2) - y3x - ((y1x <<< 2) + y1x);
	assign c3  = y3x + ((y1x <<< 1) + y1x) - ((y2x <<< 1) + y2x) - y0x;

	assign prod_hi = MA'(prod_q >>> FRAC_W);
	assign delayed = y1x + MA'(prod_q >>> (FRAC_W + 1));

	// Capture the beat, the taps and the partial results
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q     <= ch_in;
			wp_cur_q <= wp_in;
			base_q   <= IW'(base_x);
			smp_q    <= signed'(s_tdata[SB-1:0]);
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (state_q)
			fdci_pkg::ST_RD1: begin
				scaled_q <= SCW'((prod_q + PW'(fdci_pkg::ROUND_HALF)) >>> fdci_pkg::GAIN_FRAC);
				y0_q     <= ysmp;
			end
			fdci_pkg::ST_RD2: y1_q <= ysmp;
			fdci_pkg::ST_RD3: y2_q <= ysmp;
			fdci_pkg::ST_M1: begin
				c1_q <= c1;
				c2_q <= c2;
			end
			fdci_pkg::ST_M4: dly_q <= delayed;
			default: ;
		endcase
	end

	// Stored and returned sums, saturated to the sample range
	always_comb begin
		if (cfg.zero) begin
			sum_st  = SUMW'(scaled_q);
			sum_out = SUMW'(scaled_q);
		end else begin
			sum_st  = SUMW'(scaled_q) + SUMW'(prod_q >>> FRAC_W);
			sum_out = SUMW'(scaled_q) + SUMW'(dly_q);
		end
		clip_st  = (sum_st > SMAX_W) || (sum_st < SMIN_W);
		clip_out = (sum_out > SMAX_W) || (sum_out < SMIN_W);
		sat_st   = (sum_st > SMAX_W) ? SMAX_W : ((sum_st < SMIN_W) ? SMIN_W : sum_st);
		sat_out  = (sum_out > SMAX_W) ? SMAX_W : ((sum_out < SMIN_W) ? SMIN_W : sum_out);
	end

	// Output register: load a result, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (mem_we) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			m_data_q <= SB'(sat_out);
			m_clip_q <= clip_st || clip_out;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDW'(m_data_q);
	assign m_tuser  = m_clip_q;

`ifndef ASSERT_OFF
	a_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_tready)
		else $error("beat accepted while settings settle");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == fdci_pkg::ST_RD0))
		else $error("accepted beat did not start the read sequence");

	a_back_range: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.busy |-> ({1'b0, back} < DX1))
		else $error("read offset not reduced below the depth");

	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == fdci_pkg::ST_RD0) || (state_q == fdci_pkg::ST_RD1) ||
		 (state_q == fdci_pkg::ST_RD2) || (state_q == fdci_pkg::ST_RD3))
		|-> ({1'b0, rd_idx} < DX1))
		else $error("tap index outside the delay memory");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (m_tvalid && (state_q == fdci_pkg::ST_IDLE)))
		else $error("memory write without a loaded result");
`endif

endmodule
